### hdl/synth_bcd_strobe_sequencer_macros.svh
`ifndef SYNTH_BCD_STROBE_SEQUENCER_MACROS_SVH
`define SYNTH_BCD_STROBE_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sbss: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sbss: assertion failed");

`endif

### hdl/sbss_pkg.sv
package sbss_pkg;

	localparam int FreqW    = 34;
	localparam int PhaseW   = 11;
	localparam int WordW    = 16;
	localparam int DigitW   = 4;
	localparam int DigitsN  = 10;
	localparam int BcdW     = DigitsN * DigitW;
	// Binary input is padded so that it splits into whole groups of bits per step.
	localparam int DabbleBits = 3;
	localparam int StepsN   = (FreqW + DabbleBits - 1) / DabbleBits;
	localparam int BinW     = StepsN * DabbleBits;
	localparam int StepW    = $clog2(StepsN);
	localparam int WordIdxW = 4;

	localparam logic [WordW-1:0] StrobeMask = 16'h8000;
	localparam logic [WordW-1:0] EnableWord = 16'h0010;

	localparam logic [3:0] SelDigits98 = 4'd15;
	localparam logic [3:0] SelDigits76 = 4'd14;
	localparam logic [3:0] SelDigits54 = 4'd13;
	localparam logic [3:0] SelDigits32 = 4'd12;
	localparam logic [3:0] SelDigits10 = 4'd11;
	localparam logic [3:0] SelPhaseHi  = 4'd9;
	localparam logic [3:0] SelPhaseLo  = 4'd10;

	// Word positions inside a run of sixteen; a phase-only run starts at the phase pairs.
	localparam logic [WordIdxW-1:0] FirstProgIdx  = 4'd0;
	localparam logic [WordIdxW-1:0] FirstPhaseIdx = 4'd12;
	localparam logic [WordIdxW-1:0] LastIdx       = 4'd15;

	typedef struct packed {
		logic              prog;
		logic [BcdW-1:0]   bcd;
		logic [DigitW-1:0] ph_hundreds;
		logic [DigitW-1:0] ph_tens;
		logic [DigitW-1:0] ph_ones;
	} run_t;

	typedef struct packed {
		logic valid;
		run_t run;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// One double-dabble step: correct every digit, then shift in one binary bit.
	// Carries out of the top digit are dropped, which keeps the value modulo 10^10.
	function automatic logic [BcdW-1:0] dabble_step(input logic [BcdW-1:0] bcd,
			input logic bin_bit);
		logic [BcdW-1:0] adj;
		adj = bcd;
		for (int d = 0; d < DigitsN; d++) begin
			if (adj[d*DigitW +: DigitW] >= 4'd5) begin
				adj[d*DigitW +: DigitW] = adj[d*DigitW +: DigitW] + 4'd3;
			end
		end
		return {adj[BcdW-2:0], bin_bit};
	endfunction

endpackage

### hdl/sbss_if.sv
interface sbss_item_if;
	import sbss_pkg::*;
	logic              valid;
	logic              ready;
	logic [FreqW-1:0]  frequency_decihz;
	logic              program_frequency;
	logic [PhaseW-1:0] phase_steps;

	modport source (output valid, frequency_decihz, program_frequency, phase_steps,
		input ready);
	modport sink (input valid, frequency_decihz, program_frequency, phase_steps,
		output ready);
endinterface

interface sbss_result_if;
	import sbss_pkg::*;
	logic             valid;
	logic             ready;
	logic [WordW-1:0] ttl_word;
	logic             last_word;

	modport source (output valid, ttl_word, last_word, input ready);
	modport sink (input valid, ttl_word, last_word, output ready);
endinterface

### hdl/synth_bcd_strobe_sequencer.sv
// Turns each accepted item into a run of strobed 16-bit TTL words for a BCD-decade
// synthesizer: 16 words when frequency programming is requested, 4 otherwise, with
// the final word marked. Words leave one per cycle while the result side is ready.
// The front end converts the frequency to BCD three bits per cycle and then pushes the
// run; a phase-only item stops converting early. The front end finishes an item sooner
// than the back end emits its run, so programmed items can be sustained back to back.
// A two-entry queue between them lets the front end convert the next item while the
// current run is still being sent.
module synth_bcd_strobe_sequencer
	import sbss_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	sbss_item_if.sink     item,
	sbss_result_if.source result
);

	push_t         push;
	queue_status_t qstat;
	run_t          head;
	logic          pop;

	sbss_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.qstat (qstat),
		.push  (push)
	);

	sbss_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.qstat (qstat),
		.head  (head)
	);

	sbss_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.qstat (qstat),
		.head  (head),
		.pop   (pop),
		.result(result)
	);

endmodule

### hdl/sbss_front.sv
module sbss_front
	import sbss_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	sbss_item_if.sink     item,
	input  queue_status_t qstat,
	output push_t         push
);

	typedef enum logic [1:0] {IDLE, CONV, PUSH} state_t;

	state_t            state_q;
	logic [StepW-1:0]  step_q;
	logic [BinW-1:0]   bin_q;
	logic [BcdW-1:0]   bcd_q;
	logic [PhaseW-1:0] ph_q;
	logic              prog_q;
	logic [7:0]        quot_q;
	logic [DigitW-1:0] ones_q;
	logic [DigitW-1:0] tens_q;
	logic [DigitW-1:0] hund_q;

	logic [BcdW-1:0]   bcd_next;
	logic [26:0]       prod10;
	logic [7:0]        quot;
	logic [PhaseW-1:0] ones_full;
	logic [15:0]       prod100;
	logic [4:0]        quot2;
	logic [7:0]        tens_full;
	logic              accept;
	logic              do_push;
	logic              conv_done;

	always_comb begin
		bcd_next = bcd_q;
		for (int b = 0; b < DabbleBits; b++) begin
			bcd_next = dabble_step(bcd_next, bin_q[BinW-1-b]);
		end
	end

	// Exact floor division by ten for 11-bit and 8-bit operands.
	assign prod10    = 27'(ph_q) * 27'd52429;
	assign quot      = prod10[26:19];
	assign ones_full = ph_q - PhaseW'({quot, 3'b000}) - PhaseW'({quot, 1'b0});
	assign prod100   = 16'(quot_q) * 16'd205;
	assign quot2     = prod100[15:11];
	assign tens_full = quot_q - {quot2, 3'b000} - 8'({quot2, 1'b0});

	assign conv_done  = prog_q ? (step_q == StepW'(StepsN - 1)) : (step_q == StepW'(1));
	assign do_push    = (state_q == PUSH) && !qstat.full;
	assign item.ready = (state_q == IDLE) || do_push;
	assign accept     = item.valid && item.ready;

	assign push.valid           = do_push;
	assign push.run.prog        = prog_q;
	assign push.run.bcd         = bcd_q;
	assign push.run.ph_hundreds = hund_q;
	assign push.run.ph_tens     = tens_q;
	assign push.run.ph_ones     = ones_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						state_q <= CONV;
						step_q  <= '0;
					end
				end
				CONV: begin
					step_q <= step_q + StepW'(1);
					if (conv_done) begin
						state_q <= PUSH;
					end
				end
				PUSH: begin
					if (accept) begin
						state_q <= CONV;
						step_q  <= '0;
					end else if (do_push) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q  <= BinW'(item.frequency_decihz);
			bcd_q  <= '0;
			ph_q   <= item.phase_steps;
			prog_q <= item.program_frequency;
		end else if (state_q == CONV) begin
			bin_q  <= {bin_q[BinW-DabbleBits-1:0], DabbleBits'(0)};
			bcd_q  <= bcd_next;
			quot_q <= quot;
			ones_q <= ones_full[DigitW-1:0];
			tens_q <= tens_full[DigitW-1:0];
			hund_q <= quot2[DigitW-1:0];
		end
	end

endmodule

### hdl/sbss_queue.sv
module sbss_queue
	import sbss_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  push_t         push,
	input  logic          pop,
	output queue_status_t qstat,
	output run_t          head
);

	run_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign qstat.full  = (count_q == 2'd2);
	assign qstat.empty = (count_q == 2'd0);
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push.valid && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push.valid) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.run;
		end
	end

endmodule

### hdl/sbss_back.sv
module sbss_back
	import sbss_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  queue_status_t qstat,
	input  run_t          head,
	output logic          pop,
	sbss_result_if.source result
);

	logic [WordIdxW-1:0] idx_q;
	logic                started_q;
	logic                out_valid_q;
	logic [WordW-1:0]    out_word_q;
	logic                out_last_q;

	logic [WordIdxW-1:0] idx;
	logic [WordW-1:0]    base_word;
	logic [WordW-1:0]    word;
	logic                load;

	assign idx  = started_q ? idx_q : (head.prog ? FirstProgIdx : FirstPhaseIdx);
	assign load = !qstat.empty && (!out_valid_q || result.ready);
	assign pop  = load && (idx == LastIdx);

	always_comb begin
		case (idx[WordIdxW-1:1])
			3'd0: base_word = EnableWord;
			3'd1: base_word = {SelDigits98, head.bcd[39:36], head.bcd[35:32], 4'h0};
			3'd2: base_word = {SelDigits76, head.bcd[31:28], head.bcd[27:24], 4'h0};
			3'd3: base_word = {SelDigits54, head.bcd[23:20], head.bcd[19:16], 4'h0};
			3'd4: base_word = {SelDigits32, head.bcd[15:12], head.bcd[11:8], 4'h0};
			3'd5: base_word = {SelDigits10, head.bcd[7:4], head.bcd[3:0], 4'h0};
			3'd6: base_word = {SelPhaseHi, 4'h0, head.ph_hundreds, 4'h0};
			default: base_word = {SelPhaseLo, head.ph_ones, head.ph_tens, 4'h0};
		endcase
		// Even positions carry the strobe, odd positions the same word with it cleared.
		word = idx[0] ? (base_word & ~StrobeMask) : (base_word | StrobeMask);
	end

	assign result.valid     = out_valid_q;
	assign result.ttl_word  = out_word_q;
	assign result.last_word = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (idx == LastIdx) begin
					started_q <= 1'b0;
				end else begin
					started_q <= 1'b1;
					idx_q     <= idx + WordIdxW'(1);
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_word_q <= word;
			out_last_q <= (idx == LastIdx);
		end
	end

endmodule

### hdl/sbss_checker.sv
`include "synth_bcd_strobe_sequencer_macros.svh"

module sbss_checker
	import sbss_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             res_valid,
	input logic             res_ready,
	input logic [WordW-1:0] res_word,
	input logic             res_last
);

	logic res_xfer;
	assign res_xfer = res_valid && res_ready;

	// A stalled result transaction holds its payload.
	`SBSS_ASSERT_NEXT(a_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_word) && $stable(res_last))

	// Inside a run, words follow one another without a gap.
	`SBSS_ASSERT_NEXT(a_no_gap, clk, arst_n, res_xfer && !res_last, res_valid)

	// A strobed word is followed by the same word with the strobe cleared.
	`SBSS_ASSERT_NEXT(a_pair, clk, arst_n, res_xfer && res_word[15], !res_word[15] && (res_word[14:0] == $past(res_word[14:0])))

	// A run always closes on the cleared second phase word.
	`SBSS_ASSERT_NOW(a_last, clk, arst_n, res_valid && res_last, res_word[15:12] == (SelPhaseLo & 4'h7))

endmodule

bind synth_bcd_strobe_sequencer sbss_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.res_word (result.ttl_word),
	.res_last (result.last_word)
);

### sim/synth_bcd_strobe_sequencer_checker.sv
`timescale 1ns / 1ps

module synth_bcd_strobe_sequencer_checker
	import sbss_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	sbss_item_if   item,
	sbss_result_if result,
	output int     errors,
	output int     words_due
);

	typedef struct packed {
		logic [WordW-1:0] word;
		logic             last;
	} ttl_beat_t;

	ttl_beat_t ttl_words_due[$];
	int        error_tally;

	function automatic logic [WordW-1:0] digit_pair(input logic [3:0] sel,
			input logic [3:0] hi, input logic [3:0] lo);
		return {sel, hi, lo, 4'd0};
	endfunction

	// Every word leaves twice: strobe high first, then strobe low.
	task automatic push_strobed(input logic [WordW-1:0] word, input logic last);
		ttl_beat_t beat;
		beat.word = word | StrobeMask;
		beat.last = 1'b0;
		ttl_words_due.insert(ttl_words_due.size(), beat);
		beat.word = word & ~StrobeMask;
		beat.last = last;
		ttl_words_due.insert(ttl_words_due.size(), beat);
	endtask

	task automatic predict_run(input logic [FreqW-1:0] freq, input logic prog,
			input logic [PhaseW-1:0] phase);
		logic [3:0]      dig [DigitsN];
		longint unsigned rest;
		int unsigned     ph;
		rest = freq;
		ph = phase;
		// Digits above the tenth simply never get extracted.
		for (int k = 0; k < DigitsN; k++) begin
			dig[k] = 4'(rest % 10);
			rest = rest / 10;
		end
		if (prog) begin
			push_strobed(EnableWord, 1'b0);
			push_strobed(digit_pair(SelDigits98, dig[9], dig[8]), 1'b0);
			push_strobed(digit_pair(SelDigits76, dig[7], dig[6]), 1'b0);
			push_strobed(digit_pair(SelDigits54, dig[5], dig[4]), 1'b0);
			push_strobed(digit_pair(SelDigits32, dig[3], dig[2]), 1'b0);
			push_strobed(digit_pair(SelDigits10, dig[1], dig[0]), 1'b0);
		end
		push_strobed(digit_pair(SelPhaseHi, 4'd0, 4'((ph / 100) % 16)), 1'b0);
		push_strobed(digit_pair(SelPhaseLo, 4'(ph % 10), 4'((ph / 10) % 10)), 1'b1);
	endtask

	always @(posedge clk) begin
		ttl_beat_t got;
		ttl_beat_t want;
		if (arst_n) begin
			if (item.valid && item.ready) begin
				predict_run(item.frequency_decihz, item.program_frequency, item.phase_steps);
			end
			if (result.valid && result.ready) begin
				got = '{result.ttl_word, result.last_word};
				if (ttl_words_due.size() == 0) begin
					$display("%0t: unexpected transaction: expected none, got ttl_word %h last_word %b",
						$time, got.word, got.last);
					error_tally++;
				end else begin
					want = ttl_words_due.pop_front();
					if (got.word !== want.word) begin
						$display("%0t: ttl_word mismatch: expected %h, got %h",
							$time, want.word, got.word);
						error_tally++;
					end
					if (got.last !== want.last) begin
						$display("%0t: last_word mismatch: expected %b, got %b",
							$time, want.last, got.last);
						error_tally++;
					end
				end
			end
			errors <= error_tally;
			words_due <= ttl_words_due.size();
		end
	end

endmodule

### sim/synth_bcd_strobe_sequencer_tb.sv
`timescale 1ns / 1ps

module synth_bcd_strobe_sequencer_tb;
	import sbss_pkg::*;

	localparam int RandomItems = 250;
	localparam int CalmItems   = 40;
	localparam int HoldStart   = 200;
	localparam int HoldCycles  = 150;
	localparam int DrainCycles = 40;

	logic        clk;
	logic        arst_n;
	bit          calm;
	bit          long_hold;
	int          errors;
	int          words_due;
	int unsigned gap_pct;

	sbss_item_if   item_ch();
	sbss_result_if result_ch();

	synth_bcd_strobe_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	synth_bcd_strobe_sequencer_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.errors    (errors),
		.words_due (words_due)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Ten random decimal digits, so any digit value can show up in any place.
	function automatic logic [FreqW-1:0] decimal_freq();
		longint unsigned v;
		v = 0;
		for (int k = 0; k < DigitsN; k++) begin
			v = v * 10 + $urandom_range(0, 9);
		end
		return v[FreqW-1:0];
	endfunction

	function automatic logic [FreqW-1:0] random_freq();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			return decimal_freq();
		end else if (pick < 70) begin
			return {2'($urandom_range(0, 3)), 32'($urandom())};
		end else if (pick < 85) begin
			return FreqW'($urandom_range(0, 999));
		end else begin
			return FreqW'(64'd9999999990 + $urandom_range(0, 20));
		end
	endfunction

	function automatic logic [PhaseW-1:0] random_phase();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			return PhaseW'($urandom_range(0, 1600));
		end else if (pick < 90) begin
			return PhaseW'($urandom_range(0, 2047));
		end else begin
			case ($urandom_range(0, 3))
				0: return PhaseW'(0);
				1: return PhaseW'(1599);
				2: return PhaseW'(1600);
				default: return PhaseW'(2047);
			endcase
		end
	endfunction

	task automatic offer_item(input logic [FreqW-1:0] freq, input logic prog,
			input logic [PhaseW-1:0] phase);
		int unsigned gap;
		if (!calm && !long_hold && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 8);
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.frequency_decihz <= freq;
		item_ch.program_frequency <= prog;
		item_ch.phase_steps <= phase;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		calm = 1'b0;
		gap_pct = 0;
		item_ch.valid <= 1'b0;
		item_ch.frequency_decihz <= '0;
		item_ch.program_frequency <= 1'b0;
		item_ch.phase_steps <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_item(34'd0, 1'b1, 11'd0);
		offer_item(34'd9999999999, 1'b1, 11'd1599);
		offer_item({FreqW{1'b1}}, 1'b1, {PhaseW{1'b1}});
		offer_item(34'd1234567890, 1'b0, 11'd1600);
		offer_item(34'd10000000000, 1'b1, 11'd1700);
		offer_item(34'd1, 1'b1, 11'd9);
		offer_item(34'h2AAAAAAAA, 1'b1, 11'h555);
		offer_item(34'h155555555, 1'b1, 11'h2AA);
		offer_item(34'd9876543210, 1'b0, 11'd0);
		offer_item(34'd5555555555, 1'b1, 11'd1234);
		offer_item(34'd1000000000, 1'b1, 11'd100);
		offer_item({FreqW{1'b1}}, 1'b0, 11'd2047);
		offer_item(34'd0, 1'b0, 11'd1600);

		for (int n = 0; n < RandomItems; n++) begin
			if (n % 32 == 0) begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 10;
					default: gap_pct = 40;
				endcase
			end
			if (n >= RandomItems - CalmItems) begin
				calm = 1'b1;
			end
			offer_item(random_freq(), $urandom_range(0, 99) < 75, random_phase());
		end
		item_ch.valid <= 1'b0;

		@(posedge clk);
		while (words_due != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0) begin
			$display("PASS synth_bcd_strobe_sequencer");
		end else begin
			$display("FAIL synth_bcd_strobe_sequencer");
		end
		$finish;
	end

	initial begin
		int unsigned stall_left;
		int unsigned stall_pct;
		int          cyc;
		long_hold = 1'b0;
		stall_left = 0;
		stall_pct = 0;
		cyc = 0;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			// A long hold-off lets the run queue fill so the item side has to stall.
			if (cyc == HoldStart) begin
				long_hold = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				long_hold = 1'b0;
			end
			if (cyc % 64 == 0) begin
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 10;
					default: stall_pct = 35;
				endcase
			end
			if (calm) begin
				result_ch.ready <= 1'b1;
			end else if (stall_left != 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
				if ($urandom_range(0, 99) < stall_pct) begin
					stall_left = $urandom_range(1, 8);
				end
			end
			cyc++;
			@(posedge clk);
		end
	end

	initial begin
		#3000000;
		$display("FAIL synth_bcd_strobe_sequencer");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/sbss_pkg.sv
hdl/sbss_if.sv
hdl/sbss_front.sv
hdl/sbss_queue.sv
hdl/sbss_back.sv
hdl/synth_bcd_strobe_sequencer.sv
hdl/sbss_checker.sv
sim/synth_bcd_strobe_sequencer_checker.sv
sim/synth_bcd_strobe_sequencer_tb.sv
